FILE: design/bgcd_pkg.sv
`default_nettype none

package bgcd_pkg;

    localparam int FIELD_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STRIP,
        ST_REDUCE
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_STRIP,
        CMD_SHIFT_X,
        CMD_SHIFT_Y,
        CMD_SUB
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic x_odd;
        logic y_odd;
        logic y_zero;
    } status_t;

endpackage

`default_nettype wire

FILE: design/bgcd_datapath.sv
`default_nettype none

module bgcd_datapath
    import bgcd_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_t              ctrl,
    input  wire logic [FIELD_W-1:0] first_value,
    input  wire logic [FIELD_W-1:0] second_value,
    output status_t                 status,
    output logic      [FIELD_W-1:0] divisor
);

    localparam int KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0]   a_in;
    logic [WIDTH-1:0]   b_in;
    logic [WIDTH-1:0]   x_reg;
    logic [WIDTH-1:0]   x_next;
    logic [WIDTH-1:0]   y_reg;
    logic [WIDTH-1:0]   y_next;
    logic [KW-1:0]      k_reg;
    logic [KW-1:0]      k_next;
    logic [WIDTH-1:0]   shifted;
    logic [FIELD_W-1:0] result_reg;
    logic [FIELD_W-1:0] result_next;
    logic               x_gt;

    // Operands are cut or zero-extended to the working width.
    generate
        if (WIDTH > FIELD_W) begin : g_wide
            assign a_in = {{(WIDTH - FIELD_W){1'b0}}, first_value};
            assign b_in = {{(WIDTH - FIELD_W){1'b0}}, second_value};
            assign result_next = shifted[FIELD_W-1:0];
        end else if (WIDTH == FIELD_W) begin : g_equal
            assign a_in = first_value;
            assign b_in = second_value;
            assign result_next = shifted;
        end else begin : g_narrow
            assign a_in = first_value[WIDTH-1:0];
            assign b_in = second_value[WIDTH-1:0];
            assign result_next = {{(FIELD_W - WIDTH){1'b0}}, shifted};
        end
    endgenerate

    assign x_gt    = x_reg > y_reg;
    assign shifted = x_reg << k_reg;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        k_next = k_reg;
        case (ctrl.cmd)
            CMD_LOAD:
            begin
                // A zero operand always lands in y, so x is zero only when both are.
                if (a_in == '0)
                begin
                    x_next = b_in;
                    y_next = a_in;
                end
                else
                begin
                    x_next = a_in;
                    y_next = b_in;
                end
                k_next = '0;
            end
            CMD_STRIP:
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + KW'(1);
            end
            CMD_SHIFT_X:
            begin
                x_next = x_reg >> 1;
            end
            CMD_SHIFT_Y:
            begin
                y_next = y_reg >> 1;
            end
            CMD_SUB:
            begin
                if (x_gt)
                begin
                    x_next = y_reg;
                    y_next = x_reg - y_reg;
                end
                else
                begin
                    y_next = y_reg - x_reg;
                end
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        k_reg <= k_next;
        if (ctrl.out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign status.x_odd  = x_reg[0];
    assign status.y_odd  = y_reg[0];
    assign status.y_zero = (y_reg == '0);
    assign divisor       = result_reg;

    // The subtract step only ever sees two odd values.
    a_sub_odd: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.cmd == CMD_SUB |-> (x_reg[0] && y_reg[0]))
        else $error("subtract issued on an even operand");

    // A result is only captured once the second value has run down to zero.
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> (y_reg == '0))
        else $error("result captured with nonzero second value");

    // The subtract step keeps x nonzero.
    a_x_live: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.cmd == CMD_SUB |=> (x_reg != '0))
        else $error("first value dropped to zero during reduction");

endmodule

`default_nettype wire

FILE: design/bgcd_ctrl.sv
`default_nettype none

module bgcd_ctrl
    import bgcd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    operand_valid,
    output logic         operand_stall,
    output logic         result_valid,
    input  wire logic    result_stall,
    input  wire status_t status,
    output ctrl_t        ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !result_valid_reg || !result_stall;
    assign accept   = (state_reg == ST_IDLE) && operand_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (operand_valid)
                begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                if (status.y_zero || status.x_odd || status.y_odd)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (status.y_zero && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        operand_stall = 1'b1;
        ctrl.cmd      = CMD_NONE;
        ctrl.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                operand_stall = 1'b0;
                if (operand_valid)
                begin
                    ctrl.cmd = CMD_LOAD;
                end
            end
            ST_STRIP:
            begin
                if (!(status.y_zero || status.x_odd || status.y_odd))
                begin
                    ctrl.cmd = CMD_STRIP;
                end
            end
            ST_REDUCE:
            begin
                if (status.y_zero)
                begin
                    ctrl.out_load = out_free;
                end
                else if (!status.x_odd)
                begin
                    ctrl.cmd = CMD_SHIFT_X;
                end
                else if (!status.y_odd)
                begin
                    ctrl.cmd = CMD_SHIFT_Y;
                end
                else
                begin
                    ctrl.cmd = CMD_SUB;
                end
            end
            default:
            begin
                operand_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    // A finished result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> out_free)
        else $error("result register overwritten while stalled");

    // An accepted item always starts with the shared power-of-two stage.
    a_accept_strip: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_STRIP))
        else $error("accepted item did not enter strip stage");

    // Capturing a result returns to idle with the result on offer.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |=> (state_reg == ST_IDLE && result_valid_reg))
        else $error("finish did not present result and return to idle");

endmodule

`default_nettype wire

FILE: design/binary_gcd.sv
// Greatest common divisor of two unsigned operands by the binary (Stein) method.
// The operand channel carries first_value and second_value under
// operand_valid/operand_stall; an item is taken on a clock edge with valid high
// and stall low. The result channel carries divisor under
// result_valid/result_stall in the same way.
// One item is worked at a time. The load comes first, then one strip step per shared
// factor of two and a step to leave that stage, then the shift and subtract steps
// of the reduction loop, and last the capture of the result. The datapath does one
// step per cycle, save that the capture waits while the output register is full.
// The result sits in an output register, so the next item is taken while a
// finished result still waits. When the receiver stalls, the result holds, and
// a following item that finishes waits in its last step until the register
// frees. Reset clears the controller and drops result_valid; no result is
// pending after reset.
`default_nettype none

module binary_gcd
    import bgcd_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               operand_valid,
    output logic                    operand_stall,
    input  wire logic [FIELD_W-1:0] first_value,
    input  wire logic [FIELD_W-1:0] second_value,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic      [FIELD_W-1:0] divisor
);

    ctrl_t   ctrl;
    status_t status;

    bgcd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .ctrl          (ctrl)
    );

    bgcd_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .first_value  (first_value),
        .second_value (second_value),
        .status       (status),
        .divisor      (divisor)
    );

endmodule

`default_nettype wire
